FILE: rtl/hebp_pkg.sv
// ----------------------------------------------------------------------------
// hebp_pkg
// Shared types and constants for the static Huffman encoder / bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package hebp_pkg;

  // Input operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  localparam int unsigned CODE_W      = 16;  // stored code width
  localparam int unsigned LEN_W       = 6;   // queue length field, fits 0..63
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ACC_W       = BYTE_W + CODE_W;
  localparam int unsigned FIRST_BIT   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_END    = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                kind;
    logic [CODE_W-1:0]   code;
    logic [LEN_W-1:0]    len;
  } cmd_t;

endpackage : hebp_pkg

`default_nettype wire

FILE: rtl/hebp_front.sv
// ----------------------------------------------------------------------------
// hebp_front
// Accepts input transactions, writes table loads, looks up codes and hands
// encode and end commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hebp_front import hebp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         symbol_i,
  input  wire logic [15:0]        code_bits_i,
  input  wire logic [4:0]         code_length_i,
  output      logic               push_o,
  output      cmd_t               push_cmd_o,
  input  wire logic               full_i
);

  localparam int unsigned LW    = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned IDX_W = $clog2(SYMBOL_COUNT);
  localparam int unsigned ENT_W = CODE_W + LW;

  logic [ENT_W-1:0] table_mem [SYMBOL_COUNT];
  logic [ENT_W-1:0] rd_q;
  logic             s1_valid_q, s1_valid_d;
  cmd_e             s1_kind_q;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [LW-1:0]    len_sat;
  logic [CODE_W-1:0] code_m;
  logic             do_load, do_cmd;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = ({1'b0, symbol_i} < 9'(SYMBOL_COUNT));
  assign idx      = symbol_i[IDX_W-1:0];

  // saturate length, clear code bits at or above it
  always_comb begin
    if ({1'b0, code_length_i} > 6'(MAX_CODE_LEN)) begin
      len_sat = LW'(MAX_CODE_LEN);
    end else begin
      len_sat = LW'(code_length_i);
    end
    for (int i = 0; i < CODE_W; i++) begin
      code_m[i] = code_bits_i[i] && (6'(len_sat) > 6'(i));
    end
  end

  assign do_load = accept && (op_i == OP_LOAD) && in_range;
  assign do_cmd  = accept && (((op_i == OP_ENCODE) && in_range) || (op_i == OP_END));

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      table_mem[idx] <= {len_sat, code_m};
    end
    if (accept && (op_i == OP_ENCODE) && in_range) begin
      rd_q <= table_mem[idx];
    end
    if (do_cmd) begin
      s1_kind_q <= (op_i == OP_END) ? CMD_END : CMD_ENCODE;
    end
  end

  assign push_o     = s1_valid_q && !full_i;
  assign in_ready_o = !s1_valid_q || !full_i;

  always_comb begin
    push_cmd_o.kind = s1_kind_q;
    push_cmd_o.code = rd_q[CODE_W-1:0];
    push_cmd_o.len  = LEN_W'(rd_q[ENT_W-1:CODE_W]);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (push_o) begin
      s1_valid_d = 1'b0;
    end
    if (do_cmd) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

endmodule : hebp_front

`default_nettype wire

FILE: rtl/hebp_queue.sv
// ----------------------------------------------------------------------------
// hebp_queue
// Short command queue between lookup front and packer back.
// ----------------------------------------------------------------------------
`default_nettype none

module hebp_queue import hebp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output      logic full_o,
  output      logic valid_o,
  output      cmd_t head_o,
  input  wire logic pop_i
);

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_cmd_i;
    end
  end

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule : hebp_queue

`default_nettype wire

FILE: rtl/hebp_back.sv
// ----------------------------------------------------------------------------
// hebp_back
// Bit packer: appends codes to the accumulator, emits one byte per cycle
// when out_ready allows, flushes and emits the header patch at message end.
// ----------------------------------------------------------------------------
`default_nettype none

module hebp_back import hebp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire cmd_t       q_head_i,
  output      logic       pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] out_byte_o,
  output      logic       is_header_patch_o,
  output      logic       last_o
);

  localparam int unsigned TOT_W = $clog2(BYTE_W - 1 + MAX_CODE_LEN + 1);

  logic [ACC_W-1:0] acc_q, acc_d, sum_acc;
  logic [TOT_W-1:0] tot_q, tot_d, sum_tot;
  logic             phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             hdr_q, hdr_d;
  logic             last_q, last_d;
  logic             take;
  logic [2:0]       pos;

  assign take = !out_valid_q || out_ready_i;
  assign pos  = tot_q[2:0];

  always_comb begin
    sum_acc = {{CODE_W{1'b0}}, acc_q[7:0]} | (ACC_W'(q_head_i.code) << pos);
    sum_tot = tot_q + TOT_W'(q_head_i.len);
  end

  always_comb begin
    acc_d       = acc_q;
    tot_d       = tot_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    hdr_d       = hdr_q;
    last_d      = last_q;

    if (tot_q >= TOT_W'(BYTE_W)) begin
      // drain full bytes before taking the next command
      if (take) begin
        out_valid_d = 1'b1;
        byte_d      = acc_q[7:0];
        hdr_d       = 1'b0;
        last_d      = 1'b0;
        acc_d       = acc_q >> BYTE_W;
        tot_d       = tot_q - TOT_W'(BYTE_W);
      end
    end else if (q_valid_i) begin
      case (q_head_i.kind)
        CMD_ENCODE: begin
          pop_o = 1'b1;
          if ((sum_tot >= TOT_W'(BYTE_W)) && take) begin
            out_valid_d = 1'b1;
            byte_d      = sum_acc[7:0];
            hdr_d       = 1'b0;
            last_d      = 1'b0;
            acc_d       = sum_acc >> BYTE_W;
            tot_d       = sum_tot - TOT_W'(BYTE_W);
          end else begin
            acc_d = sum_acc;
            tot_d = sum_tot;
          end
        end
        CMD_END: begin
          if (take) begin
            out_valid_d = 1'b1;
            if ((pos != 3'd0) && !phase_q) begin
              // flush partial last byte
              byte_d  = acc_q[7:0];
              hdr_d   = 1'b0;
              last_d  = 1'b0;
              phase_d = 1'b1;
            end else begin
              // patch: valid bits minus one, wraps to 7 on a full byte
              byte_d  = {5'd0, pos - 3'd1};
              hdr_d   = 1'b1;
              last_d  = 1'b1;
              pop_o   = 1'b1;
              phase_d = 1'b0;
              acc_d   = '0;
              tot_d   = TOT_W'(FIRST_BIT);
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      tot_q       <= TOT_W'(FIRST_BIT);
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      tot_q       <= tot_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = byte_q;
  assign is_header_patch_o = hdr_q;
  assign last_o            = last_q;

endmodule : hebp_back

`default_nettype wire

FILE: rtl/huffman_encoder_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer
// Streaming static Huffman encoder with a byte-wide LSB-first bit packer.
// ----------------------------------------------------------------------------
// Pipeline: a result passes the lookup register, the queue and the output
//   register; a table load is written into the table when it is accepted.
// Throughput: front takes one transaction per cycle unless a looked-up command
//   waits on a full queue; the packer emits an encode's bytes in turn, an end as flush then patch.
// Reset: packer rearmed at bit position 3 with pending byte zero, queue
//   empty; code table contents are undefined until loaded. No clearing pass.
`default_nettype none

module huffman_encoder_bit_packer import hebp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [15:0] code_bits_i,
  input  wire logic [4:0]  code_length_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  out_byte_o,
  output      logic        is_header_patch_o,
  output      logic        last_o
);

  // Front -> queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // Queue -> back
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  // Front: write table loads, look up codes, classify encode / end
  hebp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .push_o        (q_push),
    .push_cmd_o    (q_push_cmd),
    .full_i        (q_full)
  );

  // Queue: decouple lookup from byte emission
  hebp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  // Back: pack bits, emit bytes, flush and patch at end of message
  hebp_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_head_i          (q_head),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .is_header_patch_o (is_header_patch_o),
    .last_o            (last_o)
  );

  // Never write into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("queue overflow");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("queue underflow");

  // Header patch and last flag always travel together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_header_patch_o == last_o))
    else $error("patch/last mismatch");

  // Header patch value fits in three bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_header_patch_o) |-> (out_byte_o[7:3] == 5'd0))
    else $error("patch value out of range");

endmodule : huffman_encoder_bit_packer

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the static Huffman encoder / bit packer. Loads
// code table entries, sends messages of encode transactions closed by end
// transactions, and checks every output byte against a bit-exact software
// copy of the packer, with random idle cycles on both channels.
// ----------------------------------------------------------------------------

module testbench;
  import hebp_pkg::*;

  // op code 3 has no meaning; the block must drop it
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned REPORT_MAX   = 10;

  // One output transaction as the block presents it
  typedef struct packed {
    logic [7:0] data;
    logic       patch;
    logic       fin;
  } stream_out_t;

  // Packer copy plus the queue of bytes it says must come out, in order
  class huff_byte_board;
    logic [15:0]  code_mem [256];
    logic [4:0]   len_mem [256];
    logic [7:0]   acc_byte;
    logic [2:0]   fill_pos;
    stream_out_t  expected_bytes [$];
    int unsigned  fault_count;

    function new();
      acc_byte    = 8'd0;
      fill_pos    = 3'(FIRST_BIT);
      fault_count = 0;
    endfunction

    // Advance the packer copy by one accepted input transaction
    function void take_item(logic [1:0] op, logic [7:0] sym, logic [15:0] code,
                            logic [4:0] len);
      logic [23:0] acc;
      int          total;
      int          eff_len;
      case (op)
        OP_LOAD: begin
          // saturate the length, clear code bits at or above it
          eff_len = (len > 5'd16) ? 16 : int'(len);
          if (eff_len < 16) code = code & 16'((32'd1 << eff_len) - 32'd1);
          code_mem[sym] = code;
          len_mem[sym]  = 5'(eff_len);
        end
        OP_ENCODE: begin
          acc   = {16'd0, acc_byte} | ({8'd0, code_mem[sym]} << fill_pos);
          total = int'(fill_pos) + int'(len_mem[sym]);
          while (total >= 8) begin
            expected_bytes.push_back(stream_out_t'({acc[7:0], 1'b0, 1'b0}));
            acc   = acc >> 8;
            total = total - 8;
          end
          acc_byte = acc[7:0];
          fill_pos = 3'(total);
        end
        OP_END: begin
          // flush a partial byte, then the header patch; a full byte gives 7
          if (fill_pos != 3'd0) begin
            expected_bytes.push_back(stream_out_t'({acc_byte, 1'b0, 1'b0}));
            expected_bytes.push_back(stream_out_t'({5'd0, fill_pos - 3'd1, 1'b1, 1'b1}));
          end else begin
            expected_bytes.push_back(stream_out_t'({8'd7, 1'b1, 1'b1}));
          end
          acc_byte = 8'd0;
          fill_pos = 3'(FIRST_BIT);
        end
        default: ;
      endcase
    endfunction

    // Compare one output transaction with the oldest expected byte
    function void check_byte(logic [7:0] data, logic patch, logic fin);
      stream_out_t want;
      if (expected_bytes.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("[%0t] unexpected output: byte=%02h patch=%0b last=%0b",
                   $realtime, data, patch, fin);
      end else begin
        want = expected_bytes.pop_front();
        if (want.data !== data || want.patch !== patch || want.fin !== fin) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display({"[%0t] mismatch: expected byte=%02h patch=%0b last=%0b,",
                      " got byte=%02h patch=%0b last=%0b"},
                     $realtime, want.data, want.patch, want.fin, data, patch, fin);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [7:0]  symbol_i;
  logic [15:0] code_bits_i;
  logic [4:0]  code_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        is_header_patch_o;
  logic        last_o;

  huff_byte_board board;
  bit             steady;          // suppress idling on both channels
  int unsigned    cycle_count;
  bit             loaded [256];    // table entries written so far
  logic [7:0]     loaded_list [$];

  huffman_encoder_bit_packer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .symbol_i          (symbol_i),
    .code_bits_i       (code_bits_i),
    .code_length_i     (code_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .is_header_patch_o (is_header_patch_o),
    .last_o            (last_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Drop ready with a probability of 8 in 100, unless a steady stretch is running
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 8);
  end

  // Check every output transaction; values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_byte(out_byte_o, is_header_patch_o, last_o);
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one input transaction: optional idle cycles first, then hold valid
  // and payload until the block takes it
  task automatic push_item(input logic [1:0] op, input logic [7:0] sym,
                           input logic [15:0] code, input logic [4:0] len);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    symbol_i      <= sym;
    code_bits_i   <= code;
    code_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_item(op, sym, code, len);
    if (op == OP_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_list.push_back(sym);
    end
  endtask

  // Hold off the sender until every expected byte has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_bytes.size() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned msg_len;
    int unsigned pick;
    bit          paused;
    logic [4:0]  rnd_len;

    board         = new();
    steady        = 1'b0;
    paused        = 1'b0;
    sent          = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_LOAD;
    symbol_i      = 8'd0;
    code_bits_i   = 16'd0;
    code_length_i = 5'd0;
    out_ready_i   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message straight after reset
    push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
    // Zero length with stray code bits, full 16 bits, saturated lengths,
    // truncated code, single-bit code
    push_item(OP_LOAD, 8'h00, 16'hFFFF, 5'd0);
    push_item(OP_LOAD, 8'hFF, 16'hFFFF, 5'd16);
    push_item(OP_LOAD, 8'hA5, 16'h8001, 5'd31);
    push_item(OP_LOAD, 8'h5A, 16'hFFFF, 5'd5);
    push_item(OP_LOAD, 8'h01, 16'h0001, 5'd1);
    push_item(OP_LOAD, 8'h80, 16'hC3A5, 5'd17);
    // Unused op code: must produce nothing
    push_item(OP_SPARE, 8'($urandom), 16'($urandom), 5'($urandom));
    // Five bits from position 3 complete the byte exactly: patch 7, no flush
    push_item(OP_ENCODE, 8'h5A, 16'($urandom), 5'($urandom));
    push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
    // Long codes emitting two bytes, a zero-length code in the middle
    push_item(OP_ENCODE, 8'hFF, 16'($urandom), 5'($urandom));
    push_item(OP_ENCODE, 8'h00, 16'($urandom), 5'($urandom));
    push_item(OP_ENCODE, 8'hA5, 16'($urandom), 5'($urandom));
    push_item(OP_ENCODE, 8'h80, 16'($urandom), 5'($urandom));
    push_item(OP_ENCODE, 8'h01, 16'($urandom), 5'($urandom));
    push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
    // Rewrite an entry and use it right away
    push_item(OP_LOAD, 8'h01, 16'h0002, 5'd2);
    push_item(OP_ENCODE, 8'h01, 16'($urandom), 5'($urandom));
    push_item(OP_ENCODE, 8'h01, 16'($urandom), 5'($urandom));
    push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
    push_item(OP_LOAD, 8'h7E, 16'h5555, 5'd15);
    push_item(OP_ENCODE, 8'h7E, 16'($urandom), 5'($urandom));
    push_item(OP_ENCODE, 8'h00, 16'($urandom), 5'($urandom));
    push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
    // Empty message again, this time after a rearm
    push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));

    // Random messages: mostly encodes of loaded symbols, loads mixed in,
    // a little op-code noise
    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent >= 120) begin
        wait_drained();
        paused = 1'b1;
      end
      msg_len = $urandom_range(0, 24);
      for (int unsigned j = 0; j < msg_len; j++) begin
        steady = (sent >= 200 && sent < 300);
        pick   = $urandom_range(0, 99);
        if (pick < 12) begin
          rnd_len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 16));
          push_item(OP_LOAD, 8'($urandom), 16'($urandom), rnd_len);
          sent++;
        end else if (pick < 14) begin
          push_item(OP_SPARE, 8'($urandom), 16'($urandom), 5'($urandom));
        end else begin
          push_item(OP_ENCODE, loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                    16'($urandom), 5'($urandom));
          sent++;
        end
      end
      push_item(OP_END, 8'($urandom), 16'($urandom), 5'($urandom));
      sent++;
    end
    steady = 1'b0;

    // Drain, then keep the clock running so the pipeline can show stray output
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (board.fault_count == 0 && board.expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
